// File: src/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg
// Shared types, codes and constants of the superseding job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sjq_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned DestCountDef  = 16;
  localparam int unsigned SeqWidth      = 32;
  localparam logic [2:0]  AttMax        = 3'd7;
  localparam logic [2:0]  MaxAttReset   = 3'd3;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_TAKE   = 2'd1,
    MODE_REPORT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    EV_QUEUED    = 4'd0,
    EV_EVICT_P   = 4'd1,
    EV_EVICT_C   = 4'd2,
    EV_DROPPED   = 4'd3,
    EV_ISSUED    = 4'd4,
    EV_EMPTY     = 4'd5,
    EV_BUSY      = 4'd6,
    EV_COMMITTED = 4'd7,
    EV_REQUEUED  = 4'd8,
    EV_FAILED    = 4'd9,
    EV_NO_FLIGHT = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MARK = 2'd1,
    ST_EXEC = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] dest;
    logic       complete;
    logic       write_ok;
  } in_word_t;

  typedef struct packed {
    logic [3:0]          event_res;
    logic [3:0]          job_dest;
    logic [SeqWidth-1:0] job_seq;
    logic                job_complete;
    logic [2:0]          job_attempts;
    logic [6:0]          queue_depth;
  } out_word_t;

  // One stored job. The superseded bit is set once a newer job for the same
  // destination has been enqueued.
  typedef struct packed {
    logic                sup;
    logic [3:0]          dest;
    logic [SeqWidth-1:0] seq;
    logic                complete;
    logic [2:0]          attempts;
  } job_t;

  typedef struct packed {
    logic load;
    logic mark;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic stall;
  } sts_t;

endpackage

`default_nettype wire

// File: src/sjq_ctrl.sv
// ----------------------------------------------------------------------------
// sjq_ctrl
// Sequencer: accept a word, mark superseded jobs, then execute it.
// ----------------------------------------------------------------------------
`default_nettype none

module sjq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sjq_pkg::sts_t sts_i,
  output sjq_pkg::cmd_t      cmd_o
);
  import sjq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MARK;
      end
      ST_MARK: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!sts_i.stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MARK: cmd_o.mark = 1'b1;
      ST_EXEC: cmd_o.exec = !sts_i.stall;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/sjq_datapath.sv
// ----------------------------------------------------------------------------
// sjq_datapath
// Row of job cells with parallel compare, in-flight slot and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sjq_datapath #(
  parameter int unsigned QUEUE_DEPTH = sjq_pkg::QueueDepthDef,
  parameter int unsigned DEST_COUNT  = sjq_pkg::DestCountDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sjq_pkg::in_word_t in_word_i,
  input  wire sjq_pkg::cmd_t     cmd_i,
  output sjq_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sjq_pkg::out_word_t     out_word_o,
  input  wire logic              cfg_valid_i,
  input  wire logic [2:0]        cfg_data_i
);
  import sjq_pkg::*;

  localparam int unsigned Slots = QUEUE_DEPTH + 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 2);

  in_word_t            in_q;
  job_t                cell_q [Slots];
  job_t                cell_d [Slots];
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [SeqWidth-1:0] next_q, next_d;
  job_t                inf_q, inf_d;
  logic                inf_v_q, inf_v_d;
  logic [2:0]          maxatt_q;
  out_word_t           out_q, out_d;
  logic                out_v_q;

  logic [3:0]       new_dest;
  job_t             nj, oj, removed, taken;
  logic [Slots-1:0] part, cpl, sel, ge;
  logic             full, shift_en, wr_en;
  logic [CW-1:0]    widx;
  event_e           ev;

  assign new_dest = 4'(in_q.dest % DEST_COUNT);
  assign sts_o.stall = out_v_q && !out_ready_i;
  assign full = cnt_q >= CW'(QUEUE_DEPTH);

  always_comb begin
    nj          = '0;
    nj.dest     = new_dest;
    nj.seq      = next_q;
    nj.complete = in_q.complete;
  end

  // Superseded candidates, oldest first, then the lowest set bit of each.
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cpl[i]  = (CW'(i) < cnt_q) && cell_q[i].sup;
      part[i] = cpl[i] && !cell_q[i].complete;
    end
  end

  always_comb begin
    removed = '0;
    taken   = cell_q[0];
    if (taken.attempts != AttMax) taken.attempts = taken.attempts + 3'd1;
    for (int i = 0; i < Slots; i++) begin
      if (sel[i]) removed = removed | cell_q[i];
    end
  end

  always_comb begin
    ev       = EV_NO_FLIGHT;
    oj       = '0;
    sel      = Slots'(1);
    shift_en = 1'b0;
    wr_en    = 1'b0;
    widx     = cnt_q;
    cnt_d    = cnt_q;
    next_d   = next_q;
    inf_d    = inf_q;
    inf_v_d  = inf_v_q;
    case (mode_e'(in_q.mode))
      MODE_ENQ: begin
        next_d = next_q + SeqWidth'(1);
        wr_en  = 1'b1;
        if (full) begin
          shift_en = 1'b1;
          widx     = cnt_q - CW'(1);
          if (|part) begin
            sel = part & (~part + Slots'(1));
            ev  = EV_EVICT_P;
          end else if (|cpl) begin
            sel = cpl & (~cpl + Slots'(1));
            ev  = EV_EVICT_C;
          end else begin
            ev  = EV_DROPPED;
          end
          oj = removed;
        end else begin
          cnt_d = cnt_q + CW'(1);
          ev    = EV_QUEUED;
          oj    = nj;
        end
      end
      MODE_TAKE: begin
        if (inf_v_q) begin
          ev = EV_BUSY;
        end else if (cnt_q == '0) begin
          ev = EV_EMPTY;
        end else begin
          shift_en = 1'b1;
          cnt_d    = cnt_q - CW'(1);
          inf_d    = taken;
          inf_v_d  = 1'b1;
          ev       = EV_ISSUED;
          oj       = taken;
        end
      end
      MODE_REPORT: begin
        if (inf_v_q) begin
          inf_v_d = 1'b0;
          inf_d   = '0;
          oj      = inf_q;
          if (in_q.write_ok) begin
            ev = EV_COMMITTED;
          end else if (inf_q.attempts < maxatt_q && !inf_q.sup &&
                       cnt_q < CW'(Slots)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CW'(1);
            ev    = EV_REQUEUED;
          end else begin
            ev = EV_FAILED;
          end
        end
      end
      default: ev = EV_NO_FLIGHT;
    endcase
  end

  assign ge = ~(sel - Slots'(1));

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cell_d[i] = cell_q[i];
      if (shift_en && ge[i] && (i < Slots - 1)) cell_d[i] = cell_q[(i + 1) % Slots];
      if (wr_en && CW'(i) == widx) begin
        cell_d[i] = (mode_e'(in_q.mode) == MODE_ENQ) ? nj : inf_q;
      end
    end
  end

  always_comb begin
    out_d              = '0;
    out_d.event_res    = ev;
    out_d.job_dest     = oj.dest;
    out_d.job_seq      = oj.seq;
    out_d.job_complete = oj.complete;
    out_d.job_attempts = oj.attempts;
    out_d.queue_depth  = 7'(cnt_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_word_i;
    if (cmd_i.exec) out_q <= out_d;
    for (int i = 0; i < Slots; i++) begin
      if (cmd_i.exec) begin
        cell_q[i] <= cell_d[i];
      end else if (cmd_i.mark && mode_e'(in_q.mode) == MODE_ENQ &&
                   cell_q[i].dest == new_dest) begin
        cell_q[i].sup <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      next_q   <= SeqWidth'(1);
      inf_q    <= '0;
      inf_v_q  <= 1'b0;
      maxatt_q <= MaxAttReset;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) maxatt_q <= cfg_data_i;
      if (cmd_i.exec) begin
        cnt_q   <= cnt_d;
        next_q  <= next_d;
        inf_q   <= inf_d;
        inf_v_q <= inf_v_d;
        out_v_q <= 1'b1;
      end else begin
        if (out_ready_i) out_v_q <= 1'b0;
        if (cmd_i.mark && mode_e'(in_q.mode) == MODE_ENQ && inf_q.dest == new_dest) begin
          inf_q.sup <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: src/superseding_job_queue.sv
// ----------------------------------------------------------------------------
// superseding_job_queue
// Bounded job queue that evicts superseded jobs when full.
// ----------------------------------------------------------------------------
// Usage: each input word carries a mode (enqueue, take, report result) and
// the job fields. Every accepted word yields exactly one output word with an
// event code, the job it concerns and the queue depth after the step.
// Sequencing: an accepted word passes through accept, superseded marking over
// all cells in parallel and execute, and the result appears in the output
// register in the cycle after execution. The three-state sequencer takes a
// new word only after the previous one has executed; it may accept one while
// the previous result still waits in the output register.
// If the receiver stalls with a result pending, the execute step waits until
// the output register is free, and input ready stays low meanwhile.
// The configuration channel writes max_attempts at any time it is valid;
// writes are meant to occur only while the block is idle.
// Reset empties the queue, clears the in-flight slot, restarts sequence
// numbers at one and sets max_attempts to three. The job cells themselves
// are not cleared; only cells below the fill count ever affect a result.
// ----------------------------------------------------------------------------
`default_nettype none

module superseding_job_queue #(
  parameter int unsigned QUEUE_DEPTH = sjq_pkg::QueueDepthDef,
  parameter int unsigned DEST_COUNT  = sjq_pkg::DestCountDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sjq_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sjq_pkg::out_word_t     out_word_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_data_i
);
  import sjq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The register write is always taken at once.
  assign cfg_ready_o = 1'b1;

  sjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sjq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DEST_COUNT  (DEST_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire
